FILE: rtl/gcve_pkg.sv
// Shared types, codes and constants of the ghost cell velocity extrapolation block.
package gcve_pkg;

  localparam int WORD_BITS = 32;
  localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [33:0] VEL_MAX = 34'((64'd1 << (SAT_BITS - 1)) - 64'd1);

  localparam int ROOT_W    = 31;
  localparam int BETA_W    = 17;
  localparam int QUOT_W    = 34;
  localparam logic [16:0] BETA_HALF = 17'd32768;

  // configuration register indexes
  localparam logic [2:0] CFG_CENTER_X    = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [2:0] CFG_RADIUS      = 3'd2;
  localparam logic [2:0] CFG_CELL_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_CELL_HEIGHT = 3'd4;

  localparam logic signed [31:0] RST_CENTER_X    = 32'sd65536;
  localparam logic signed [31:0] RST_CENTER_Y    = 32'sd32768;
  localparam logic [30:0]        RST_RADIUS      = 31'd6554;
  localparam logic [30:0]        RST_CELL_WIDTH  = 31'd512;
  localparam logic [30:0]        RST_CELL_HEIGHT = 31'd512;

  // chosen side
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_BOTTOM = 2'd2;
  localparam logic [1:0] DIR_TOP    = 2'd3;

  // fault codes
  localparam logic [2:0] FLT_OK     = 3'd0;
  localparam logic [2:0] FLT_NOINT  = 3'd1;
  localparam logic [2:0] FLT_NONE   = 3'd2;
  localparam logic [2:0] FLT_BOTH   = 3'd3;
  localparam logic [2:0] FLT_CENTER = 3'd4;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] vel_left_near;
    logic signed [31:0] vel_left_far;
    logic signed [31:0] vel_right_near;
    logic signed [31:0] vel_right_far;
    logic signed [31:0] vel_down_near;
    logic signed [31:0] vel_down_far;
    logic signed [31:0] vel_up_near;
    logic signed [31:0] vel_up_far;
  } in_t;

  typedef struct packed {
    logic signed [31:0] velocity_out;
    logic [1:0]         direction;
    logic [16:0]        wall_fraction;
    logic [2:0]         fault;
  } out_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic [30:0]        cell_width;
    logic [30:0]        cell_height;
  } cfg_t;

  // per-word sideband carried down the front half
  typedef struct packed {
    logic [1:0]         dir;
    logic [2:0]         fault;
    logic signed [31:0] u1;
    logic signed [31:0] u2;
  } side_t;

  // per-word sideband carried down the back half
  typedef struct packed {
    logic [1:0]  dir;
    logic [2:0]  fault;
    logic [16:0] beta;
  } tag_t;

endpackage

FILE: rtl/gcve_ifs.sv
// Valid/ready channel interfaces for input and result words.
interface gcve_in_if;
  logic           valid;
  logic           ready;
  gcve_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcve_out_if;
  logic           valid;
  logic           ready;
  gcve_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ghost_cell_velocity_extrapolation.sv
// Top level of the ghost cell velocity extrapolation pipeline.
//
//   channel   direction  handshake               word
//   in_ch     in         valid/ready             solid point + 8 neighbor velocities
//   out_ch    out        valid/ready             velocity, side, beta, fault
//   cfg_*     in         cfg_we, no back-press   register index + 32-bit data
//
// One word enters per cycle when the output is free or being taken; every word
// passes 4 front stages, 31 square-root stages (one root bit each), 20 stages
// for the segment test and beta division (one quotient bit per divider stage),
// 40 stages for weights and the rounding division (one quotient bit per
// divider stage), and the output register. A stall at out_ch freezes the whole
// pipe in place, so in_ch.ready is low exactly while a finished word waits and
// is not taken. Reset (rst_n low, synchronous) clears every valid bit and loads
// the configuration reset values.
module ghost_cell_velocity_extrapolation (
  input  logic                clk,
  input  logic                rst_n,
  gcve_in_if.sink             in_ch,
  gcve_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // configuration registers
  gcve_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x    <= gcve_pkg::RST_CENTER_X;
      cfg_r.center_y    <= gcve_pkg::RST_CENTER_Y;
      cfg_r.radius      <= gcve_pkg::RST_RADIUS;
      cfg_r.cell_width  <= gcve_pkg::RST_CELL_WIDTH;
      cfg_r.cell_height <= gcve_pkg::RST_CELL_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcve_pkg::CFG_CENTER_X:    cfg_r.center_x    <= cfg_wdata;
        gcve_pkg::CFG_CENTER_Y:    cfg_r.center_y    <= cfg_wdata;
        gcve_pkg::CFG_RADIUS:      cfg_r.radius      <= cfg_wdata[30:0];
        gcve_pkg::CFG_CELL_WIDTH:  cfg_r.cell_width  <= cfg_wdata[30:0];
        gcve_pkg::CFG_CELL_HEIGHT: cfg_r.cell_height <= cfg_wdata[30:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // advance the whole pipe whenever the output slot is free or being taken
  logic            adv;
  logic            out_vld_r;
  gcve_pkg::out_t  out_data_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // offsets, side choice, radicand
  logic                fr_vld;
  logic [61:0]         fr_rad;
  logic signed [32:0]  fr_along;
  logic [30:0]         fr_step;
  gcve_pkg::side_t     fr_side;

  gcve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data),
    .cfg      (cfg_r),
    .vld      (fr_vld),
    .rad_v    (fr_rad),
    .along    (fr_along),
    .step     (fr_step),
    .side     (fr_side)
  );

  // half chord across the chosen axis
  logic                sq_vld;
  logic [30:0]         sq_root;
  logic signed [32:0]  sq_along;
  logic [30:0]         sq_step;
  gcve_pkg::side_t     sq_side;

  gcve_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .rad_v    (fr_rad),
    .in_along (fr_along),
    .in_step  (fr_step),
    .in_side  (fr_side),
    .vld      (sq_vld),
    .root     (sq_root),
    .along    (sq_along),
    .step     (sq_step),
    .side     (sq_side)
  );

  // cut on the segment and beta
  logic             bt_vld;
  logic [16:0]      bt_beta;
  gcve_pkg::side_t  bt_side;

  gcve_beta u_beta (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sq_vld),
    .root     (sq_root),
    .in_along (sq_along),
    .in_step  (sq_step),
    .in_side  (sq_side),
    .vld      (bt_vld),
    .beta     (bt_beta),
    .side     (bt_side)
  );

  // weighted, rounded velocity magnitude
  logic            vl_vld, vl_neg;
  logic [33:0]     vl_quot;
  gcve_pkg::tag_t  vl_tag;

  gcve_vel u_vel (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (bt_vld),
    .in_beta (bt_beta),
    .in_side (bt_side),
    .vld     (vl_vld),
    .quot    (vl_quot),
    .neg     (vl_neg),
    .tag     (vl_tag)
  );

  // saturate, apply sign, zero the payload of faulted words
  logic [33:0]     lim;
  logic [33:0]     mag_sat;
  gcve_pkg::out_t  out_nxt;

  assign lim     = vl_neg ? gcve_pkg::VEL_MAX + 34'd1 : gcve_pkg::VEL_MAX;
  assign mag_sat = (vl_quot > lim) ? lim : vl_quot;

  always_comb begin
    out_nxt.direction = vl_tag.dir;
    out_nxt.fault     = vl_tag.fault;
    if (vl_tag.fault == gcve_pkg::FLT_OK) begin
      out_nxt.velocity_out = vl_neg ? 32'(-mag_sat) : 32'(mag_sat);
      out_nxt.wall_fraction = vl_tag.beta;
    end else begin
      out_nxt.velocity_out  = 32'sd0;
      out_nxt.wall_fraction = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vl_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

endmodule

FILE: rtl/gcve_front.sv
// Front stages: offsets, side choice, neighbor select, squares and radicand.
module gcve_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  gcve_pkg::in_t             in_data,
  input  gcve_pkg::cfg_t            cfg,
  output logic                      vld,
  output logic [61:0]               rad_v,
  output logic signed [32:0]        along,
  output logic [30:0]               step,
  output gcve_pkg::side_t           side
);

  // stage A: offsets from the centre
  logic                a_vld_r;
  logic signed [32:0]  a_ox_r, a_oy_r;
  gcve_pkg::in_t       a_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ox_r   <= 33'(in_data.point_x) - 33'(cfg.center_x);
      a_oy_r   <= 33'(in_data.point_y) - 33'(cfg.center_y);
      a_data_r <= in_data;
    end
  end

  // stage B: pick the side
  logic [31:0]          ax, ay;
  logic                 horiz, at_center;
  gcve_pkg::side_t      b_side_nxt;
  logic signed [32:0]   b_along_nxt;
  logic [31:0]          b_acr_nxt;
  logic [30:0]          b_step_nxt;

  assign ax = a_ox_r[32] ? 32'(-a_ox_r) : a_ox_r[31:0];
  assign ay = a_oy_r[32] ? 32'(-a_oy_r) : a_oy_r[31:0];
  assign horiz     = ax > ay;
  assign at_center = (a_ox_r == 33'sd0) && (a_oy_r == 33'sd0);

  always_comb begin
    b_along_nxt = horiz ? a_ox_r : a_oy_r;
    b_acr_nxt   = horiz ? ay : ax;
    b_step_nxt  = horiz ? cfg.cell_width : cfg.cell_height;
    b_side_nxt.fault = at_center ? gcve_pkg::FLT_CENTER : gcve_pkg::FLT_OK;
    priority if (at_center) begin
      b_side_nxt.dir = gcve_pkg::DIR_LEFT;
    end else if (horiz) begin
      b_side_nxt.dir = (a_ox_r > 33'sd0) ? gcve_pkg::DIR_RIGHT : gcve_pkg::DIR_LEFT;
    end else begin
      b_side_nxt.dir = (a_oy_r > 33'sd0) ? gcve_pkg::DIR_TOP : gcve_pkg::DIR_BOTTOM;
    end
    unique case (b_side_nxt.dir)
      gcve_pkg::DIR_LEFT: begin
        b_side_nxt.u1 = a_data_r.vel_left_near;
        b_side_nxt.u2 = a_data_r.vel_left_far;
      end
      gcve_pkg::DIR_RIGHT: begin
        b_side_nxt.u1 = a_data_r.vel_right_near;
        b_side_nxt.u2 = a_data_r.vel_right_far;
      end
      gcve_pkg::DIR_BOTTOM: begin
        b_side_nxt.u1 = a_data_r.vel_down_near;
        b_side_nxt.u2 = a_data_r.vel_down_far;
      end
      default: begin
        b_side_nxt.u1 = a_data_r.vel_up_near;
        b_side_nxt.u2 = a_data_r.vel_up_far;
      end
    endcase
  end

  logic                b_vld_r;
  logic signed [32:0]  b_along_r;
  logic [31:0]         b_acr_r;
  logic [30:0]         b_step_r;
  gcve_pkg::side_t     b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_along_r <= b_along_nxt;
      b_acr_r   <= b_acr_nxt;
      b_step_r  <= b_step_nxt;
      b_side_r  <= b_side_nxt;
    end
  end

  // stage C: squares
  logic [63:0]         c_sq_nxt;
  logic [61:0]         c_r2_nxt;
  logic                c_vld_r;
  logic [63:0]         c_sq_r;
  logic [61:0]         c_r2_r;
  logic signed [32:0]  c_along_r;
  logic [30:0]         c_step_r;
  gcve_pkg::side_t     c_side_r;

  assign c_sq_nxt = b_acr_r * b_acr_r;
  assign c_r2_nxt = cfg.radius * cfg.radius;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sq_r    <= c_sq_nxt;
      c_r2_r    <= c_r2_nxt;
      c_along_r <= b_along_r;
      c_step_r  <= b_step_r;
      c_side_r  <= b_side_r;
    end
  end

  // stage D: radicand and early faults
  gcve_pkg::side_t     d_side_nxt;
  logic [61:0]         d_rad_nxt;
  logic                d_vld_r;
  logic [61:0]         d_rad_r;
  logic signed [32:0]  d_along_r;
  logic [30:0]         d_step_r;
  gcve_pkg::side_t     d_side_r;

  always_comb begin
    d_side_nxt = c_side_r;
    d_rad_nxt  = 62'({2'b0, c_r2_r} - c_sq_r);
    if (c_side_r.fault == gcve_pkg::FLT_OK) begin
      priority if ({2'b0, c_r2_r} < c_sq_r) begin
        d_side_nxt.fault = gcve_pkg::FLT_NOINT;
      end else if (c_step_r == 31'd0) begin
        d_side_nxt.fault = gcve_pkg::FLT_NONE;
      end else begin
        d_side_nxt.fault = gcve_pkg::FLT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rad_r   <= d_rad_nxt;
      d_along_r <= c_along_r;
      d_step_r  <= c_step_r;
      d_side_r  <= d_side_nxt;
    end
  end

  assign vld   = d_vld_r;
  assign rad_v = d_rad_r;
  assign along = d_along_r;
  assign step  = d_step_r;
  assign side  = d_side_r;

endmodule

FILE: rtl/gcve_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module gcve_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [61:0]          rad_v,
  input  logic signed [32:0]   in_along,
  input  logic [30:0]          in_step,
  input  gcve_pkg::side_t      in_side,
  output logic                 vld,
  output logic [30:0]          root,
  output logic signed [32:0]   along,
  output logic [30:0]          step,
  output gcve_pkg::side_t      side
);

  localparam int N = gcve_pkg::ROOT_W;

  logic                vld_r   [0:N-1];
  logic [61:0]         rem_r   [0:N-1];
  logic [30:0]         root_r  [0:N-1];
  logic signed [32:0]  along_r [0:N-1];
  logic [30:0]         step_r  [0:N-1];
  gcve_pkg::side_t     side_r  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BIT = N - 1 - k;
    logic                vld_in;
    logic [61:0]         rem_in, trial;
    logic [30:0]         root_in;
    logic signed [32:0]  along_in;
    logic [30:0]         step_in;
    gcve_pkg::side_t     side_in;
    logic                ge;

    if (k == 0) begin : g_first
      assign vld_in   = in_vld;
      assign rem_in   = rad_v;
      assign root_in  = 31'd0;
      assign along_in = in_along;
      assign step_in  = in_step;
      assign side_in  = in_side;
    end else begin : g_next
      assign vld_in   = vld_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
      assign along_in = along_r[k-1];
      assign step_in  = step_r[k-1];
      assign side_in  = side_r[k-1];
    end

    // (root + 2^BIT)^2 - root^2
    assign trial = ({31'b0, root_in} << (BIT + 1)) | (62'd1 << (2 * BIT));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]   <= ge ? rem_in - trial : rem_in;
        root_r[k]  <= root_in | (31'(ge) << BIT);
        along_r[k] <= along_in;
        step_r[k]  <= step_in;
        side_r[k]  <= side_in;
      end
    end
  end

  assign vld   = vld_r[N-1];
  assign root  = root_r[N-1];
  assign along = along_r[N-1];
  assign step  = step_r[N-1];
  assign side  = side_r[N-1];

endmodule

FILE: rtl/gcve_beta.sv
// Segment cut test, wall distance and pipelined beta division.
module gcve_beta (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [30:0]          root,
  input  logic signed [32:0]   in_along,
  input  logic [30:0]          in_step,
  input  gcve_pkg::side_t      in_side,
  output logic                 vld,
  output logic [16:0]          beta,
  output gcve_pkg::side_t      side
);

  localparam int N = gcve_pkg::BETA_W;

  // stage E: segment ends
  logic signed [33:0]  along34, step34, end_pt;
  logic                odd_in;
  assign along34 = 34'(in_along);
  assign step34  = 34'($signed({1'b0, in_step}));
  assign odd_in  = in_side.dir[0];
  assign end_pt  = odd_in ? along34 + step34 : along34 - step34;

  logic                e_vld_r;
  logic signed [33:0]  e_lo_r, e_hi_r, e_along_r;
  logic [30:0]         e_root_r, e_step_r;
  gcve_pkg::side_t     e_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_lo_r    <= odd_in ? along34 : end_pt;
      e_hi_r    <= odd_in ? end_pt : along34;
      e_along_r <= along34;
      e_root_r  <= root;
      e_step_r  <= in_step;
      e_side_r  <= in_side;
    end
  end

  // stage F: which cut points lie on the segment
  logic signed [33:0]  sp, sn;
  logic                on1, on2;
  gcve_pkg::side_t     f_side_nxt;
  assign sp  = 34'($signed({1'b0, e_root_r}));
  assign sn  = -sp;
  assign on1 = (e_lo_r <= sp) && (sp <= e_hi_r);
  assign on2 = (e_lo_r <= sn) && (sn <= e_hi_r);

  always_comb begin
    f_side_nxt = e_side_r;
    if (e_side_r.fault == gcve_pkg::FLT_OK) begin
      priority if (!on1 && !on2) begin
        f_side_nxt.fault = gcve_pkg::FLT_NONE;
      end else if (on1 && on2) begin
        f_side_nxt.fault = gcve_pkg::FLT_BOTH;
      end else begin
        f_side_nxt.fault = gcve_pkg::FLT_OK;
      end
    end
  end

  logic                f_vld_r, f_on1_r;
  logic signed [33:0]  f_along_r, f_sp_r;
  logic [30:0]         f_step_r;
  gcve_pkg::side_t     f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_on1_r   <= on1;
      f_along_r <= e_along_r;
      f_sp_r    <= sp;
      f_step_r  <= e_step_r;
      f_side_r  <= f_side_nxt;
    end
  end

  // stage G: distance to the cut, never more than one cell
  logic signed [33:0]  hit, gap;
  assign hit = f_on1_r ? f_sp_r : -f_sp_r;
  assign gap = f_side_r.dir[0] ? hit - f_along_r : f_along_r - hit;

  logic                g_vld_r;
  logic [30:0]         g_dist_r, g_step_r;
  gcve_pkg::side_t     g_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (adv) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_dist_r <= gap[30:0];
      g_step_r <= f_step_r;
      g_side_r <= f_side_r;
    end
  end

  // distance * 2^16 / step, one quotient bit per stage
  logic                vld_r  [0:N-1];
  logic [31:0]         rem_r  [0:N-1];
  logic [16:0]         q_r    [0:N-1];
  logic [30:0]         step_r [0:N-1];
  gcve_pkg::side_t     side_r [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_div
    localparam int BIT = N - 1 - k;
    logic              vld_in, ge;
    logic [31:0]       rem_in;
    logic [16:0]       q_in;
    logic [30:0]       step_in;
    gcve_pkg::side_t   side_in;

    if (k == 0) begin : g_first
      assign vld_in  = g_vld_r;
      assign rem_in  = {1'b0, g_dist_r};
      assign q_in    = 17'd0;
      assign step_in = g_step_r;
      assign side_in = g_side_r;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = {rem_r[k-1][30:0], 1'b0};
      assign q_in    = q_r[k-1];
      assign step_in = step_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign ge = rem_in >= {1'b0, step_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? rem_in - {1'b0, step_in} : rem_in;
        q_r[k]    <= q_in | (17'(ge) << BIT);
        step_r[k] <= step_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld  = vld_r[N-1];
  assign beta = q_r[N-1];
  assign side = side_r[N-1];

endmodule

FILE: rtl/gcve_vel.sv
// Quadratic weights, weighted velocity and pipelined rounding division.
module gcve_vel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [16:0]          in_beta,
  input  gcve_pkg::side_t      in_side,
  output logic                 vld,
  output logic [33:0]          quot,
  output logic                 neg,
  output gcve_pkg::tag_t       tag
);

  localparam int N = gcve_pkg::QUOT_W;

  // V1: weight coefficients
  logic                low_beta;
  logic signed [20:0]  c1_nxt, c2_nxt, b21, b8;
  assign low_beta = in_beta < gcve_pkg::BETA_HALF;
  assign b21      = 21'($signed({4'b0, in_beta}));
  assign b8       = $signed({1'b0, in_beta, 3'b0});

  always_comb begin
    if (low_beta) begin
      c1_nxt = b21 + b21 - 21'sd262144;
      c2_nxt = 21'sd65536 - b21;
    end else begin
      c1_nxt = b8 - 21'sd655360;
      c2_nxt = 21'sd327680 - b8;
    end
  end

  logic                v1_vld_r, v1_small_r;
  logic signed [20:0]  v1_c1_r, v1_c2_r;
  logic [15:0]         v1_k_r;
  logic [16:0]         v1_da_r;
  logic [17:0]         v1_db_r;
  logic signed [31:0]  v1_u1_r, v1_u2_r;
  gcve_pkg::tag_t      v1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
    end else if (adv) begin
      v1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_small_r     <= low_beta;
      v1_c1_r        <= c1_nxt;
      v1_c2_r        <= c2_nxt;
      v1_k_r         <= low_beta ? in_beta[15:0] : 16'd1;
      v1_da_r        <= 17'(18'd65536 - {1'b0, in_beta});
      v1_db_r        <= 18'd131072 - {1'b0, in_beta};
      v1_u1_r        <= in_side.u1;
      v1_u2_r        <= in_side.u2;
      v1_tag_r.dir   <= in_side.dir;
      v1_tag_r.fault <= in_side.fault;
      v1_tag_r.beta  <= in_beta;
    end
  end

  // V2: products and divisor
  logic                v2_vld_r;
  logic signed [52:0]  v2_p1_r, v2_p2_r;
  logic [33:0]         v2_d_r;
  logic [15:0]         v2_k_r;
  gcve_pkg::tag_t      v2_tag_r;
  logic [34:0]         dd;
  assign dd = v1_da_r * v1_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_vld_r <= 1'b0;
    end else if (adv) begin
      v2_vld_r <= v1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v2_p1_r  <= 53'(v1_c1_r) * 53'(v1_u1_r);
      v2_p2_r  <= 53'(v1_c2_r) * 53'(v1_u2_r);
      v2_d_r   <= v1_small_r ? dd[33:0] : 34'd196608;
      v2_k_r   <= v1_k_r;
      v2_tag_r <= v1_tag_r;
    end
  end

  // V3: numerator
  logic                v3_vld_r;
  logic signed [53:0]  v3_n_r;
  logic [33:0]         v3_d_r;
  logic [15:0]         v3_k_r;
  gcve_pkg::tag_t      v3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_vld_r <= 1'b0;
    end else if (adv) begin
      v3_vld_r <= v2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v3_n_r   <= 54'(v2_p1_r) + 54'(v2_p2_r);
      v3_d_r   <= v2_d_r;
      v3_k_r   <= v2_k_r;
      v3_tag_r <= v2_tag_r;
    end
  end

  // V4: magnitude and sign
  logic                v4_vld_r, v4_neg_r;
  logic [51:0]         v4_m_r;
  logic [33:0]         v4_d_r;
  logic [15:0]         v4_k_r;
  gcve_pkg::tag_t      v4_tag_r;
  logic signed [53:0]  n_abs;
  assign n_abs = v3_n_r[53] ? -v3_n_r : v3_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_vld_r <= 1'b0;
    end else if (adv) begin
      v4_vld_r <= v3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v4_neg_r <= v3_n_r[53];
      v4_m_r   <= n_abs[51:0];
      v4_d_r   <= v3_d_r;
      v4_k_r   <= v3_k_r;
      v4_tag_r <= v3_tag_r;
    end
  end

  // V5: scale by k in two halves
  logic                v5_vld_r, v5_neg_r;
  logic [41:0]         v5_plo_r, v5_phi_r;
  logic [33:0]         v5_d_r;
  gcve_pkg::tag_t      v5_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_vld_r <= 1'b0;
    end else if (adv) begin
      v5_vld_r <= v4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v5_neg_r <= v4_neg_r;
      v5_plo_r <= v4_m_r[25:0] * v4_k_r;
      v5_phi_r <= v4_m_r[51:26] * v4_k_r;
      v5_d_r   <= v4_d_r;
      v5_tag_r <= v4_tag_r;
    end
  end

  // V6: dividend with half divisor for rounding
  logic [65:0]         num_nxt;
  logic                v6_vld_r, v6_neg_r;
  logic [31:0]         v6_hi_r;
  logic [33:0]         v6_lo_r, v6_d_r;
  gcve_pkg::tag_t      v6_tag_r;
  assign num_nxt = 66'({v5_phi_r, 26'b0}) + 66'(v5_plo_r) + 66'(v5_d_r[33:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_vld_r <= 1'b0;
    end else if (adv) begin
      v6_vld_r <= v5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v6_neg_r <= v5_neg_r;
      v6_hi_r  <= num_nxt[65:34];
      v6_lo_r  <= num_nxt[33:0];
      v6_d_r   <= v5_d_r;
      v6_tag_r <= v5_tag_r;
    end
  end

  // restoring division, one quotient bit per stage
  logic                vld_r [0:N-1];
  logic                neg_r [0:N-1];
  logic [34:0]         rem_r [0:N-1];
  logic [33:0]         lo_r  [0:N-1];
  logic [33:0]         d_r   [0:N-1];
  logic [33:0]         q_r   [0:N-1];
  gcve_pkg::tag_t      tag_r [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_div
    localparam int BIT = N - 1 - k;
    logic              vld_in, neg_in, ge;
    logic [34:0]       rem_in, shifted;
    logic [33:0]       lo_in, d_in, q_in;
    gcve_pkg::tag_t    tag_in;

    if (k == 0) begin : g_first
      assign vld_in = v6_vld_r;
      assign neg_in = v6_neg_r;
      assign rem_in = {3'b0, v6_hi_r};
      assign lo_in  = v6_lo_r;
      assign d_in   = v6_d_r;
      assign q_in   = 34'd0;
      assign tag_in = v6_tag_r;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign neg_in = neg_r[k-1];
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign d_in   = d_r[k-1];
      assign q_in   = q_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign shifted = {rem_in[33:0], lo_in[BIT]};
    assign ge      = shifted >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? shifted - {1'b0, d_in} : shifted;
        q_r[k]   <= q_in | (34'(ge) << BIT);
        neg_r[k] <= neg_in;
        lo_r[k]  <= lo_in;
        d_r[k]   <= d_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign vld  = vld_r[N-1];
  assign quot = q_r[N-1];
  assign neg  = neg_r[N-1];
  assign tag  = tag_r[N-1];

endmodule

FILE: bench/tb.sv
// Self-checking bench for the ghost cell velocity extrapolation pipeline.
module tb;
  import gcve_pkg::*;

  localparam int          LATENCY    = 96;
  localparam int          QUIET_MAX  = 4000;
  localparam int          RAND_WORDS = 1730;
  localparam int          NPHASE     = 7;
  localparam logic [2:0]  CFG_SPARE  = 3'd5;  // index the block ignores
  localparam longint      Q_ONE      = 65536;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vn;
    logic signed [31:0] vf;
    bit                 typed;
    out_t               want;
  } row_t;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
    logic [30:0]        cw;
    logic [30:0]        ch;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  gcve_in_if  in_ch ();
  gcve_out_if out_ch ();

  ghost_cell_velocity_extrapolation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the circle and grid registers
  cfg_t shadow;

  out_t pending_q[$];
  int   mismatches = 0;
  bit   calm = 1'b0;    // no idling on either side while set
  int   quiet = 0;

  // --------------------------------------------------------------------------
  // Predictor: exact integer form of the extrapolation, 64-bit wraparound kept
  // --------------------------------------------------------------------------
  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // round |n|*k/d to nearest, ties away from zero, then saturate to a word
  function automatic longint round_sat(longint n, longint unsigned k, longint unsigned d);
    longint unsigned m, q, r, res, lim;
    m = mag(n);
    q = m / d;
    r = m % d;
    res = q * k + (r * k + d / 2) / d;
    lim = 64'h7FFF_FFFF;
    if (n < 0) begin
      if (res > lim + 1) res = lim + 1;
      return -longint'(res);
    end
    if (res > lim) res = lim;
    return longint'(res);
  endfunction

  function automatic out_t extrapolate(in_t w);
    out_t o;
    longint ox, oy, along, across, s, fin, lo, hi, hit, u1, u2, b, n, vel;
    longint unsigned acr, r2, stp, gap, beta, d;
    bit horiz, on1, on2;
    logic [1:0] side;
    logic [2:0] flt;
    ox = longint'(w.point_x) - longint'(shadow.center_x);
    oy = longint'(w.point_y) - longint'(shadow.center_y);
    side = DIR_LEFT;
    flt = FLT_OK;
    beta = 0;
    vel = 0;
    if (ox == 0 && oy == 0) begin
      flt = FLT_CENTER;
    end else begin
      horiz = mag(ox) > mag(oy);
      along = horiz ? ox : oy;
      across = horiz ? oy : ox;
      stp = horiz ? longint'(shadow.cell_width) : longint'(shadow.cell_height);
      acr = mag(across);
      r2 = longint'(shadow.radius) * longint'(shadow.radius);
      if (horiz) side = (ox > 0) ? DIR_RIGHT : DIR_LEFT;
      else side = (oy > 0) ? DIR_TOP : DIR_BOTTOM;
      if (r2 < acr * acr) begin
        flt = FLT_NOINT;
      end else if (stp == 0) begin
        flt = FLT_NONE;
      end else begin
        s = int_sqrt(r2 - acr * acr);
        fin = side[0] ? along + longint'(stp) : along - longint'(stp);
        lo = (along < fin) ? along : fin;
        hi = (along < fin) ? fin : along;
        on1 = lo <= s && s <= hi;
        on2 = lo <= -s && -s <= hi;
        if (!on1 && !on2) begin
          flt = FLT_NONE;
        end else if (on1 && on2) begin
          flt = FLT_BOTH;
        end else begin
          hit = on1 ? s : -s;
          gap = mag(hit - along);
          case (side)
            DIR_LEFT:   begin u1 = w.vel_left_near;  u2 = w.vel_left_far;  end
            DIR_RIGHT:  begin u1 = w.vel_right_near; u2 = w.vel_right_far; end
            DIR_BOTTOM: begin u1 = w.vel_down_near;  u2 = w.vel_down_far;  end
            default:    begin u1 = w.vel_up_near;    u2 = w.vel_up_far;    end
          endcase
          beta = gap * Q_ONE / stp;
          if (beta > Q_ONE) beta = Q_ONE;
          b = longint'(beta);
          if (b < Q_ONE / 2) begin
            n = u2 * (Q_ONE - b) - 2 * u1 * (2 * Q_ONE - b);
            d = (Q_ONE - b) * (2 * Q_ONE - b);
            vel = round_sat(n, b, d);
          end else begin
            n = (8 * b - 10 * Q_ONE) * u1 + (5 * Q_ONE - 8 * b) * u2;
            vel = round_sat(n, 1, 3 * Q_ONE);
          end
        end
      end
    end
    o.velocity_out = vel[31:0];
    o.direction = side;
    o.wall_fraction = beta[16:0];
    o.fault = flt;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed points sit just inside the circle on a random side so the cut
  // usually falls within one cell; the rest are noise.
  function automatic in_t make_word();
    in_t w;
    longint rad, stp, along, across, px, py;
    logic [1:0] side;
    w.vel_left_near  = rand_vel();
    w.vel_left_far   = rand_vel();
    w.vel_right_near = rand_vel();
    w.vel_right_far  = rand_vel();
    w.vel_down_near  = rand_vel();
    w.vel_down_far   = rand_vel();
    w.vel_up_near    = rand_vel();
    w.vel_up_far     = rand_vel();
    if ($urandom_range(0, 99) < 75) begin
      side = 2'($urandom_range(0, 3));
      rad = shadow.radius;
      stp = side[1] ? longint'(shadow.cell_height) : longint'(shadow.cell_width);
      along = rad - longint'($urandom_range(0, 32'((stp < rad) ? stp : rad)));
      if ($urandom_range(0, 9) == 0) along = rad;
      across = longint'($urandom_range(0, 32'(along / 2)));
      if ($urandom_range(0, 1)) across = -across;
      if (side == DIR_LEFT || side == DIR_BOTTOM) along = -along;
      if (side[1]) begin
        px = across;
        py = along;
      end else begin
        px = along;
        py = across;
      end
      w.point_x = 32'(longint'(shadow.center_x) + px);
      w.point_y = 32'(longint'(shadow.center_y) + py);
    end else if ($urandom_range(0, 1)) begin
      w.point_x = $urandom;
      w.point_y = $urandom;
    end else begin
      w.point_x = shadow.center_x + 32'($signed($urandom_range(0, 64)) - 32);
      w.point_y = shadow.center_y + 32'($signed($urandom_range(0, 64)) - 32);
    end
    return w;
  endfunction

  // Hold the word until it is taken; record what the block must return.
  task automatic send_word(in_t w, bit typed, out_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(typed ? want : extrapolate(w));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_CENTER_X:    shadow.center_x = value;
      CFG_CENTER_Y:    shadow.center_y = value;
      CFG_RADIUS:      shadow.radius = value[30:0];
      CFG_CELL_WIDTH:  shadow.cell_width = value[30:0];
      CFG_CELL_HEIGHT: shadow.cell_height = value[30:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(setting_t st);
    write_reg(CFG_CENTER_X, st.cx);
    write_reg(CFG_CENTER_Y, st.cy);
    write_reg(CFG_RADIUS, {1'b0, st.rad});
    write_reg(CFG_CELL_WIDTH, {1'b0, st.cw});
    write_reg(CFG_CELL_HEIGHT, {1'b0, st.ch});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    out_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word velocity=%0d dir=%0d beta=%0d fault=%0d",
                 $time, got.velocity_out, got.direction, got.wall_fraction, got.fault);
      end else begin
        want = pending_q.pop_front();
        if (got.velocity_out !== want.velocity_out) begin
          mismatches++;
          $display("%0t: velocity_out expected %0d got %0d",
                   $time, want.velocity_out, got.velocity_out);
        end
        if (got.direction !== want.direction) begin
          mismatches++;
          $display("%0t: direction expected %0d got %0d",
                   $time, want.direction, got.direction);
        end
        if (got.wall_fraction !== want.wall_fraction) begin
          mismatches++;
          $display("%0t: wall_fraction expected %0d got %0d",
                   $time, want.wall_fraction, got.wall_fraction);
        end
        if (got.fault !== want.fault) begin
          mismatches++;
          $display("%0t: fault expected %0d got %0d", $time, want.fault, got.fault);
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t     rows[12];
    setting_t plan[NPHASE];
    in_t      w;
    out_t     none;
    int       per_phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CENTER_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    none = '0;
    shadow.center_x    = RST_CENTER_X;
    shadow.center_y    = RST_CENTER_Y;
    shadow.radius      = RST_RADIUS;
    shadow.cell_width  = RST_CELL_WIDTH;
    shadow.cell_height = RST_CELL_HEIGHT;

    // Directed words against the reset circle: center (1.0, 0.5), r 6554,
    // cells 512. Only the trivial outcomes are typed in.
    rows[0]  = '{32'sd65536, 32'sd32768, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
                 '{32'sd0, DIR_LEFT, 17'd0, FLT_CENTER}};
    rows[1]  = '{32'sd165536, 32'sd82768, 32'sd65536, 32'sd65536, 1,
                 '{32'sd0, DIR_RIGHT, 17'd0, FLT_NOINT}};
    rows[2]  = '{32'sd165536, 32'sd32768, 32'sd65536, 32'sd65536, 1,
                 '{32'sd0, DIR_RIGHT, 17'd0, FLT_NONE}};
    rows[3]  = '{32'sd71990, 32'sd32768, 32'sd65536, 32'sd131072, 0, none};
    rows[4]  = '{32'sd59282, 32'sd32768, -32'sd65536, 32'sd131072, 0, none};
    rows[5]  = '{32'sd65536, 32'sd39066, 32'sd12345, -32'sd98765, 0, none};
    rows[6]  = '{32'sd65536, 32'sd26726, 32'sd65536, -32'sd65536, 0, none};
    rows[7]  = '{32'sd72090, 32'sd32768, 32'sd65536, 32'sd131072, 0, none};
    rows[8]  = '{32'sd71990, 32'sd32768, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, none};
    rows[9]  = '{32'sd71990, 32'sd32768, 32'sh8000_0000, 32'sh8000_0000, 0, none};
    rows[10] = '{32'sd71990, 32'sd38768, 32'sd65536, 32'sd65536, 0, none};
    rows[11] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, none};

    plan[0] = '{32'sd0, 32'sd0, 31'd655360, 31'd65536, 31'd32768};
    plan[1] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF};
    plan[2] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 31'd1000, 31'd100000, 31'd100000};
    plan[3] = '{32'sd4096, -32'sd4096, 31'd0, 31'd1, 31'd1};
    for (int p = 4; p < NPHASE; p++) begin
      plan[p] = '{$urandom, $urandom, 31'($urandom_range(1, 1 << 20)),
                  31'($urandom_range(1, 1 << 18)), 31'($urandom_range(1, 1 << 18))};
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      w = '{rows[i].px, rows[i].py, rows[i].vn, rows[i].vf, rows[i].vn, rows[i].vf,
            rows[i].vn, rows[i].vf, rows[i].vn, rows[i].vf};
      send_word(w, rows[i].typed, rows[i].want);
    end

    per_phase = RAND_WORDS / NPHASE;
    for (int p = 0; p < NPHASE; p++) begin
      drain();
      load_setting(plan[p]);
      // the spare index must leave every register alone
      if (p == 2) begin
        write_reg(CFG_SPARE, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      for (int i = 0; i < per_phase; i++) begin
        calm = (p == 1 && i >= 50 && i < 200);
        // hold the sender once until the pipe has emptied completely
        if (p == 0 && i == per_phase / 2) drain();
        send_word(make_word(), 1'b0, none);
      end
      calm = 1'b0;
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gcve_pkg.sv
rtl/gcve_ifs.sv
rtl/gcve_front.sv
rtl/gcve_sqrt.sv
rtl/gcve_beta.sv
rtl/gcve_vel.sv
rtl/ghost_cell_velocity_extrapolation.sv
bench/tb.sv
